// ===== sv/tsq_pkg.sv =====
`default_nettype none

package tsq_pkg;

    // Default number of triples summed into one average.
    localparam int AVG_SAMPLES_DEF = 4;

    // Field widths.
    localparam int WORD_W  = 16;
    localparam int VAL_W   = 12;
    localparam int TAG_W   = 3;
    localparam int PLIM_W  = 13;
    localparam int STAT_W  = 3;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 13;

    // Converter word layout.
    localparam int PEN_BIT = 15;
    localparam int TAG_LSB = 12;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_LIFTED = 3'd0;
    localparam logic [STAT_W-1:0] ST_START  = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOISE  = 3'd2;
    localparam logic [STAT_W-1:0] ST_ACCUM  = 3'd3;
    localparam logic [STAT_W-1:0] ST_AVG    = 3'd4;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_THRESH = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_FILT   = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_PLIM   = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_TAG_X  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_TAG_Y  = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_TAG_P  = 3'd5;

    // Configuration reset values.
    localparam logic [VAL_W-1:0]  RST_THRESH = 12'd15;
    localparam logic              RST_FILT   = 1'b1;
    localparam logic [PLIM_W-1:0] RST_PLIM   = 13'd1024;
    localparam logic [TAG_W-1:0]  RST_TAG_X  = 3'd1;
    localparam logic [TAG_W-1:0]  RST_TAG_Y  = 3'd2;
    localparam logic [TAG_W-1:0]  RST_TAG_P  = 3'd3;

    // Triple sequencer phases.
    localparam logic [1:0] PH_X      = 2'd0;
    localparam logic [1:0] PH_Y      = 2'd1;
    localparam logic [1:0] PH_P      = 2'd2;
    localparam logic [1:0] PH_UNUSED = 2'd3;

endpackage

`default_nettype wire

// ===== sv/touch_sample_qualifier_core.sv =====
`default_nettype none

// Channel   | Direction | Handshake                       | Payload
// ----------+-----------+---------------------------------+------------------------------------
// sample    | in        | i_sample_valid / o_sample_ready | i_sample_word[15:0]
// result    | out       | o_result_valid / i_result_ready | o_status, o_x_avg, o_y_avg, o_p_avg
// cfg       | in        | i_cfg_valid / o_cfg_ready       | i_cfg_index[2:0], i_cfg_data[12:0]
//
// One word per cycle is sustained while the output is not blocked: a word is held in the input register,
// where the sequencer, noise filter and accumulators update in a single pass,
// and its result (if any) is written to the output register when the stage advances.
// Result valid is driven by the output register, which follows the input register.
// Reset (synchronous, active low) clears the sequencer and restores register defaults.
// The input stage stalls only while it holds a result-producing word and the
// output register is full and not being taken.

module touch_sample_qualifier_core #(
    parameter int AVG_SAMPLES = tsq_pkg::AVG_SAMPLES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,

    input  wire logic                        i_sample_valid,
    output logic                             o_sample_ready,
    input  wire logic [tsq_pkg::WORD_W-1:0]  i_sample_word,

    output logic                             o_result_valid,
    input  wire logic                        i_result_ready,
    output logic [tsq_pkg::STAT_W-1:0]       o_status,
    output logic [tsq_pkg::VAL_W-1:0]        o_x_avg,
    output logic [tsq_pkg::VAL_W-1:0]        o_y_avg,
    output logic [tsq_pkg::VAL_W-1:0]        o_p_avg,

    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [tsq_pkg::CIDX_W-1:0]  i_cfg_index,
    input  wire logic [tsq_pkg::CDATA_W-1:0] i_cfg_data
);

    localparam int VAL_W  = tsq_pkg::VAL_W;
    localparam int LOG_N  = $clog2(AVG_SAMPLES);
    localparam int SUM_W  = VAL_W + LOG_N;
    localparam int CNT_W  = LOG_N + 1;
    // Reciprocal for exact truncating division of a SUM_W-bit sum.
    localparam int SHIFT  = SUM_W + LOG_N;
    localparam longint RECIP = ((64'd1 << SHIFT) + AVG_SAMPLES - 1) / AVG_SAMPLES;
    localparam int RCP_W  = SHIFT + 1;
    localparam int PROD_W = SUM_W + RCP_W;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(AVG_SAMPLES);

    // Configuration registers.
    logic [VAL_W-1:0]            r_thresh;
    logic                        r_filt;
    logic [tsq_pkg::PLIM_W-1:0]  r_plim;
    logic [tsq_pkg::TAG_W-1:0]   r_tag_x, r_tag_y, r_tag_p;

    // Input stage.
    logic                        r_in_vld;
    logic [tsq_pkg::WORD_W-1:0]  r_word;

    // Qualifier state.
    logic                        r_pen, n_pen;
    logic [1:0]                  r_phase, n_phase;
    logic                        r_np, n_np;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic [VAL_W-1:0]            r_hx, n_hx, r_hy, n_hy, r_hp, n_hp;
    logic [VAL_W-1:0]            r_px, n_px, r_py, n_py;
    logic [SUM_W-1:0]            r_sx, n_sx, r_sy, n_sy, r_sp, n_sp;

    // Output register.
    logic                        r_out_vld;
    logic [tsq_pkg::STAT_W-1:0]  r_status, n_status;
    logic [VAL_W-1:0]            r_xa, n_xa, r_ya, n_ya, r_pa, n_pa;

    logic                        res_vld;
    logic                        adv;
    logic                        out_free;
    logic                        pen;
    logic [tsq_pkg::TAG_W-1:0]   tag;
    logic [VAL_W-1:0]            val;
    logic [VAL_W-1:0]            hp_eff;
    logic [VAL_W-1:0]            dx, dy;
    logic                        jump;
    logic [CNT_W-1:0]            cnt_inc;
    logic [PROD_W-1:0]           prod_x, prod_y, prod_p;

    assign pen = r_word[tsq_pkg::PEN_BIT];
    assign tag = r_word[tsq_pkg::TAG_LSB +: tsq_pkg::TAG_W];
    assign val = r_word[VAL_W-1:0];

    // Handshake: the stage advances unless it owes a result to a full output.
    assign out_free       = !r_out_vld || i_result_ready;
    assign adv            = r_in_vld && (out_free || !res_vld);
    assign o_sample_ready = !r_in_vld || adv;
    assign o_cfg_ready    = 1'b1;

    // Distances to the previous accepted position.
    assign dx   = (r_px > r_hx) ? r_px - r_hx : r_hx - r_px;
    assign dy   = (r_py > r_hy) ? r_py - r_hy : r_hy - r_py;
    assign jump = r_filt && ((dx > r_thresh) || (dy > r_thresh));

    // Pressure phase keeps the old value for a wrong tag or a reading at or over the limit.
    assign hp_eff = ((tag == r_tag_p) && ({1'b0, val} < r_plim)) ? val : r_hp;
    assign cnt_inc = r_cnt + CNT_W'(1);

    // Averages by reciprocal multiply of the updated sums.
    assign prod_x = PROD_W'(n_sx) * PROD_W'(RECIP);
    assign prod_y = PROD_W'(n_sy) * PROD_W'(RECIP);
    assign prod_p = PROD_W'(n_sp) * PROD_W'(RECIP);

    // Sequencer, noise filter and accumulation for the word in the input register.
    always_comb begin
        n_pen    = r_pen;
        n_phase  = r_phase;
        n_np     = r_np;
        n_cnt    = r_cnt;
        n_hx     = r_hx;
        n_hy     = r_hy;
        n_hp     = r_hp;
        n_px     = r_px;
        n_py     = r_py;
        n_sx     = r_sx;
        n_sy     = r_sy;
        n_sp     = r_sp;
        res_vld  = 1'b0;
        n_status = tsq_pkg::ST_LIFTED;
        n_xa     = '0;
        n_ya     = '0;
        n_pa     = '0;
        if (!pen) begin
            n_phase = tsq_pkg::PH_X;
            n_cnt   = '0;
            if (r_pen) begin
                n_pen   = 1'b0;
                res_vld = 1'b1;
            end
        end else begin
            case (r_phase)
                tsq_pkg::PH_Y: begin
                    if (tag == r_tag_y) begin
                        n_hy    = val;
                        n_phase = tsq_pkg::PH_P;
                    end else begin
                        n_phase = tsq_pkg::PH_X;
                    end
                end
                tsq_pkg::PH_P: begin
                    n_hp    = hp_eff;
                    n_phase = tsq_pkg::PH_X;
                    res_vld = 1'b1;
                    if (r_pen && jump && !r_np) begin
                        n_np     = 1'b1;
                        n_status = tsq_pkg::ST_NOISE;
                    end else begin
                        if (r_pen && !jump) begin
                            n_np = 1'b0;
                        end
                        n_px = r_hx;
                        n_py = r_hy;
                        if (!r_pen) begin
                            n_pen    = 1'b1;
                            n_cnt    = '0;
                            n_np     = 1'b0;
                            n_status = tsq_pkg::ST_START;
                        end else begin
                            if (r_cnt == '0) begin
                                n_sx = SUM_W'(r_hx);
                                n_sy = SUM_W'(r_hy);
                                n_sp = SUM_W'(hp_eff);
                            end else begin
                                n_sx = r_sx + SUM_W'(r_hx);
                                n_sy = r_sy + SUM_W'(r_hy);
                                n_sp = r_sp + SUM_W'(hp_eff);
                            end
                            if (cnt_inc == CNT_LAST) begin
                                n_cnt    = '0;
                                n_status = tsq_pkg::ST_AVG;
                                n_xa     = prod_x[SHIFT +: VAL_W];
                                n_ya     = prod_y[SHIFT +: VAL_W];
                                n_pa     = prod_p[SHIFT +: VAL_W];
                            end else begin
                                n_cnt    = cnt_inc;
                                n_status = tsq_pkg::ST_ACCUM;
                            end
                        end
                    end
                end
                default: begin
                    // X phase; the unused phase code behaves the same way.
                    if (tag == r_tag_x) begin
                        n_hx    = val;
                        n_phase = tsq_pkg::PH_Y;
                    end else begin
                        n_phase = tsq_pkg::PH_X;
                    end
                end
            endcase
        end
    end

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh  <= tsq_pkg::RST_THRESH;
            r_filt    <= tsq_pkg::RST_FILT;
            r_plim    <= tsq_pkg::RST_PLIM;
            r_tag_x   <= tsq_pkg::RST_TAG_X;
            r_tag_y   <= tsq_pkg::RST_TAG_Y;
            r_tag_p   <= tsq_pkg::RST_TAG_P;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_pen     <= 1'b0;
            r_phase   <= tsq_pkg::PH_X;
            r_np      <= 1'b0;
            r_cnt     <= '0;
            r_hp      <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    tsq_pkg::CFG_THRESH: r_thresh <= i_cfg_data[VAL_W-1:0];
                    tsq_pkg::CFG_FILT:   r_filt   <= i_cfg_data[0];
                    tsq_pkg::CFG_PLIM:   r_plim   <= i_cfg_data[tsq_pkg::PLIM_W-1:0];
                    tsq_pkg::CFG_TAG_X:  r_tag_x  <= i_cfg_data[tsq_pkg::TAG_W-1:0];
                    tsq_pkg::CFG_TAG_Y:  r_tag_y  <= i_cfg_data[tsq_pkg::TAG_W-1:0];
                    tsq_pkg::CFG_TAG_P:  r_tag_p  <= i_cfg_data[tsq_pkg::TAG_W-1:0];
                    default: ;
                endcase
            end
            if (o_sample_ready) begin
                r_in_vld <= i_sample_valid;
            end
            if (adv && res_vld) begin
                r_out_vld <= 1'b1;
            end else if (i_result_ready) begin
                r_out_vld <= 1'b0;
            end
            if (adv) begin
                r_pen   <= n_pen;
                r_phase <= n_phase;
                r_np    <= n_np;
                r_cnt   <= n_cnt;
                r_hp    <= n_hp;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_sample_ready && i_sample_valid) begin
            r_word <= i_sample_word;
        end
        if (adv) begin
            r_hx <= n_hx;
            r_hy <= n_hy;
            r_px <= n_px;
            r_py <= n_py;
            r_sx <= n_sx;
            r_sy <= n_sy;
            r_sp <= n_sp;
        end
        if (adv && res_vld) begin
            r_status <= n_status;
            r_xa     <= n_xa;
            r_ya     <= n_ya;
            r_pa     <= n_pa;
        end
    end

    assign o_result_valid = r_out_vld;
    assign o_status       = r_status;
    assign o_x_avg        = r_xa;
    assign o_y_avg        = r_ya;
    assign o_p_avg        = r_pa;

`ifndef SYNTHESIS
    // The sequencer never enters its unused phase.
    a_phase_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != tsq_pkg::PH_UNUSED)
        else $error("sequencer entered the unused phase");

    // The triple count stays below the averaging length.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CNT_LAST)
        else $error("triple count reached the averaging length");

    // Averages are zero on every result that is not an average.
    a_avg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status != tsq_pkg::ST_AVG) |->
        (o_x_avg == '0 && o_y_avg == '0 && o_p_avg == '0))
        else $error("nonzero average on a status result");

    // The input stage only stalls behind a full, blocked output register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !o_sample_ready) |-> (o_result_valid && !i_result_ready))
        else $error("input stage stalled without output back pressure");
`endif

endmodule

`default_nettype wire
